FILE: hw/rtl/okm_pkg.sv
`default_nettype none
package okm_pkg;
   localparam int CAPACITY   = 256;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 64;
   localparam int VAL_W      = 32;
   localparam int KB_W       = 7;
   localparam int QDEPTH     = 2;

   typedef enum logic [2:0] {
      ACT_FIND    = 3'd0,
      ACT_CLOSEST = 3'd1,
      ACT_INSERT  = 3'd2,
      ACT_UPDATE  = 3'd3,
      ACT_UPSERT  = 3'd4,
      ACT_DELETE  = 3'd5,
      ACT_BAD6    = 3'd6,
      ACT_BAD7    = 3'd7
   } action_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      action_type       action;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] lower_key;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] key_out;
      logic [VAL_W-1:0] value_out;
      logic [1:0]       status;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_SCAN, BK_FETCH, BK_WAIT, BK_WRITE, BK_DONE
   } back_state_type;

   function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
      logic [KEY_W-1:0] m;
      m = '1;
      if (kb == '0) m = {{(KEY_W-1){1'b0}}, 1'b1};
      else if (kb < KB_W'(KEY_W)) m = ~({KEY_W{1'b1}} << kb);
      return m;
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/okm_front.sv
`default_nettype none
module okm_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [okm_pkg::KB_W-1:0] key_bits,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [2:0]               in_action,
   input  wire logic [63:0]              in_key,
   input  wire logic [63:0]              in_lower,
   input  wire logic [31:0]              in_value,
   output logic                          q_valid,
   input  wire logic                     q_ready,
   output okm_pkg::cmd_type              q_cmd
);
   import okm_pkg::*;
   localparam int PW = $clog2(QDEPTH);
   cmd_type           mem_ff [QDEPTH];
   logic [PW-1:0]     wp_ff, rp_ff;
   logic [PW:0]       cnt_ff;
   logic [KEY_W-1:0]  mask;
   cmd_type           cmd;
   logic              push, pop;

   assign mask = key_mask(key_bits);
   always_comb begin
      cmd.action    = action_type'(in_action);
      cmd.key       = in_key & mask;
      cmd.lower_key = in_lower & mask;
      cmd.value     = in_value;
   end
   assign in_ready = cnt_ff != (PW+1)'(QDEPTH);
   assign q_valid  = cnt_ff != '0;
   assign q_cmd    = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= cmd;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QDEPTH)) else $error("queue overflow");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("push lost");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("pop lost");
endmodule
`default_nettype wire

FILE: hw/rtl/okm_back.sv
`default_nettype none
module okm_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire logic          q_valid,
   output logic               q_ready,
   input  wire okm_pkg::cmd_type q_cmd,
   output logic               r_valid,
   input  wire logic          r_ready,
   output okm_pkg::rsp_type   r_data
);
   import okm_pkg::*;
   logic [KEY_W-1:0]      key_mem [CAPACITY];
   logic [VAL_W-1:0]      val_mem [CAPACITY];
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS-1:0]  raddr;
   logic [KEY_W-1:0]      rkey_ff;
   logic [VAL_W-1:0]      rval_ff;
   logic                  hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SLOT_BITS-1:0]  hit_ff_idx, hit_in_idx, free_ff, free_in;
   logic                  best_ok_ff, best_ok_in;
   logic [KEY_W-1:0]      best_key_ff, best_key_in;
   logic [SLOT_BITS-1:0]  best_ff, best_in;
   logic                  we;
   logic [SLOT_BITS-1:0]  waddr;
   rsp_type               rsp_ff, rsp_in;
   logic                  rv_ff, rv_in;
   logic [SLOT_BITS-1:0]  cur;

   assign cur   = idx_ff[SLOT_BITS-1:0];
   assign raddr = (state_ff == BK_FETCH) ? best_ff : cur;
   always_ff @(posedge clock) begin
      rkey_ff <= key_mem[raddr];
      rval_ff <= val_mem[raddr];
      if (we) begin
         key_mem[waddr] <= cmd_ff.key;
         val_mem[waddr] <= cmd_ff.value;
      end
   end

   assign q_ready = state_ff == BK_IDLE;
   assign r_valid = rv_ff;
   assign r_data  = rsp_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; idx_in = idx_ff;
      valid_in = valid_ff; count_in = count_ff;
      hit_in = hit_ff; hit_in_idx = hit_ff_idx; free_ok_in = free_ok_ff; free_in = free_ff;
      best_ok_in = best_ok_ff; best_key_in = best_key_ff; best_in = best_ff;
      rsp_in = rsp_ff; rv_in = rv_ff; we = 1'b0; waddr = free_ff;
      if (rv_ff && r_ready) rv_in = 1'b0;
      unique case (state_ff)
         BK_IDLE: if (q_valid) begin
            cmd_in = q_cmd; idx_in = '0; hit_in = 1'b0; free_ok_in = 1'b0;
            best_ok_in = 1'b0; state_in = BK_READ;
         end
         BK_READ: state_in = BK_SCAN;
         BK_SCAN: begin
            if (valid_ff[cur]) begin
               if (rkey_ff == cmd_ff.key && !hit_ff) begin
                  hit_in = 1'b1; hit_in_idx = cur;
               end
               if (rkey_ff <= cmd_ff.key && rkey_ff >= cmd_ff.lower_key &&
                   (!best_ok_ff || rkey_ff > best_key_ff)) begin
                  best_ok_in = 1'b1; best_key_in = rkey_ff; best_in = cur;
               end
            end else if (!free_ok_ff) begin
               free_ok_in = 1'b1; free_in = cur;
            end
            if (idx_ff == COUNT_BITS'(CAPACITY - 1)) begin
               state_in = BK_WRITE;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = BK_READ;
            end
         end
         // hold the commit until the previous result item has left
         BK_WRITE: if (!rv_ff) begin
            rsp_in = '0; rsp_in.status = ST_ABSENT;
            state_in = BK_DONE;
            unique case (cmd_ff.action)
               ACT_FIND: if (hit_ff) begin
                  best_in = hit_ff_idx; state_in = BK_FETCH;
               end
               ACT_CLOSEST: if (best_ok_ff) state_in = BK_FETCH;
               ACT_INSERT, ACT_UPDATE, ACT_UPSERT: begin
                  if (hit_ff) begin
                     if (cmd_ff.action != ACT_INSERT) begin
                        we = 1'b1; waddr = hit_ff_idx; rsp_in.status = ST_OK;
                     end
                  end else if (cmd_ff.action != ACT_UPDATE) begin
                     if (!free_ok_ff || count_ff >= COUNT_BITS'(CAPACITY)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        we = 1'b1; waddr = free_ff; valid_in[free_ff] = 1'b1;
                        count_in = count_ff + 1'b1; rsp_in.status = ST_OK;
                     end
                  end
               end
               ACT_DELETE: if (hit_ff) begin
                  valid_in[hit_ff_idx] = 1'b0; rsp_in.status = ST_OK;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
               end
               default: ;
            endcase
         end
         BK_FETCH: state_in = BK_WAIT;
         BK_WAIT: begin
            rsp_in.found = 1'b1; rsp_in.key_out = rkey_ff;
            rsp_in.value_out = rval_ff; rsp_in.status = ST_OK;
            state_in = BK_DONE;
         end
         BK_DONE: if (!rv_ff) begin
            rsp_in.entry_count = count_ff; rv_in = 1'b1; state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
      if (clear) begin
         valid_in = '0; count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; idx_ff <= idx_in; hit_ff_idx <= hit_in_idx; free_ff <= free_in;
      best_key_ff <= best_key_in; best_ff <= best_in; rsp_ff <= rsp_in;
      hit_ff <= hit_in; free_ok_ff <= free_ok_in; best_ok_ff <= best_ok_in;
      if (reset) begin
         state_ff <= BK_IDLE; valid_ff <= '0; count_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; count_ff <= count_in; rv_ff <= rv_in;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(valid_ff))) else $error("count mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !r_ready |=> rv_ff && $stable(rsp_ff)) else $error("result dropped");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> state_ff == BK_READ) else $error("item not started");
endmodule
`default_nettype wire

FILE: hw/rtl/ordered_key_map_with_predecessor.sv
// Ordered key map with closest-below search, up to 256 keys with 32-bit values.
// req_ channel: one item per request (action, key, lower_key, value in tdata).
// rsp_ channel: exactly one result item per request, in request order.
// csr_ channel: writes key_bits (7 bits); a write empties the store. Write
// only while no request is outstanding.
// A two-entry front queue masks keys and takes requests while the back end
// works. The back end sweeps all 256 slots of a key/value memory with one read
// and one write port, reading (BK_READ) and then checking (BK_SCAN) each slot,
// then commits the write or fetches the entry. Each request passes the front
// queue, the sweep, the commit (BK_WRITE) and the result register (BK_DONE);
// lookup hits add the fetch states BK_FETCH and BK_WAIT. The back end takes a
// new item only after it has handed its last result to the result register.
// When rsp_tready is low the result holds in its register; the next item
// sweeps but waits before its commit, the front queue fills and then drops
// req_tready.
// Reset is synchronous, active high: empty store, key_bits 64, queues empty.
`default_nettype none
module ordered_key_map_with_predecessor (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[2:0], key[66:3], lower_key[130:67], value[162:131], zero fill
   input  wire logic [167:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // found[0], key_out[64:1], value_out[96:65], status[98:97], entry_count[107:99]
   output logic [111:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_data
);
   import okm_pkg::*;
   logic [KB_W-1:0] kb_ff;
   logic            clear;
   logic            q_valid, q_ready;
   cmd_type         q_cmd;
   rsp_type         r;

   assign csr_ready = 1'b1;
   assign clear = csr_valid;
   always_ff @(posedge clock) begin
      if (reset) kb_ff <= KB_W'(64);
      else if (csr_valid) kb_ff <= csr_data;
   end

   okm_front u_front (
      .clock, .reset, .key_bits(kb_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tdata[2:0]), .in_key(req_tdata[66:3]),
      .in_lower(req_tdata[130:67]), .in_value(req_tdata[162:131]),
      .q_valid, .q_ready, .q_cmd
   );

   okm_back u_back (
      .clock, .reset, .clear, .q_valid, .q_ready, .q_cmd,
      .r_valid(rsp_tvalid), .r_ready(rsp_tready), .r_data(r)
   );

   assign rsp_tdata = {4'b0, r.entry_count, r.status, r.value_out, r.key_out, r.found};
endmodule
`default_nettype wire
